>>> rtl/core/dpsi_pkg.sv
// Shared constants, codes and types for the deposit prefix-sum index.
package dpsi_pkg;

	// Table depth and derived index / count widths
	localparam int ENTRIES = 1024;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	// Command codes
	localparam logic [1:0] CMD_PUSH     = 2'd0;
	localparam logic [1:0] CMD_POP_ONE  = 2'd1;
	localparam logic [1:0] CMD_POP_FROM = 2'd2;
	localparam logic [1:0] CMD_QUERY    = 2'd3;

	// Status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_AMOUNT   = 3'd1;
	localparam logic [2:0] ST_INTEREST = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;

	// One table entry as stored in the memory
	typedef struct packed {
		logic [31:0] height;
		logic [63:0] amount;
		logic [63:0] interest;
	} entry_t;

	// Controller -> datapath commands
	typedef struct packed {
		logic capture;
		logic exec;
		logic step;
		logic settle;
		logic fetch;
		logic load;
		logic finish;
	} dp_ctl_t;

	// Datapath -> controller status
	typedef struct packed {
		logic exec_search;
		logic exec_fetch;
		logic srch_live;
		logic srch_found;
	} dp_stat_t;

endpackage

>>> rtl/core/dpsi_ctrl.sv
// Sequencer for the deposit prefix-sum index: handshakes and command steps.
module dpsi_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  dpsi_pkg::dp_stat_t stat,
	output dpsi_pkg::dp_ctl_t  ctl
);
	import dpsi_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_SEARCH = 3'd2;
	localparam logic [2:0] S_FETCH  = 3'd3;
	localparam logic [2:0] S_LOAD   = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_n;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctl     = '0;
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_n     = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				if (stat.exec_search) begin
					state_n = S_SEARCH;
				end else if (stat.exec_fetch) begin
					state_n = S_FETCH;
				end else begin
					state_n = S_DONE;
				end
			end
			S_SEARCH: begin
				if (stat.srch_live) begin
					ctl.step = 1'b1;
				end else begin
					ctl.settle = 1'b1;
					state_n    = stat.srch_found ? S_FETCH : S_DONE;
				end
			end
			S_FETCH: begin
				ctl.fetch = 1'b1;
				state_n   = S_LOAD;
			end
			S_LOAD: begin
				ctl.load = 1'b1;
				state_n  = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					ctl.finish = 1'b1;
					state_n    = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (ctl.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/dpsi_datapath.sv
// Datapath: entry memory, running totals, binary search unit and result registers.
module dpsi_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  dpsi_pkg::dp_ctl_t    ctl,
	output dpsi_pkg::dp_stat_t   stat,
	input  logic [1:0]          cmd,
	input  logic signed [63:0]  block_amount,
	input  logic [63:0]         block_interest,
	input  logic [31:0]         target_height,
	output logic signed [63:0]  total_amount,
	output logic [63:0]         total_interest,
	output logic signed [63:0]  amount_at_height,
	output logic [63:0]         interest_at_height,
	output logic [31:0]         blocks_now,
	output logic [31:0]         blocks_removed,
	output logic [2:0]          status
);
	import dpsi_pkg::*;

	// captured beat
	logic [1:0]  cmd_q;
	logic [63:0] amt_q;
	logic [63:0] intr_q;
	logic [31:0] h_q;

	// architectural state
	logic [CNT_W-1:0] count_q;
	logic [31:0]      bc_q;
	logic [31:0]      last_height_q;
	logic [63:0]      last_amount_q;
	logic [63:0]      last_interest_q;

	// search / fetch
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hi_q;
	logic [IDX_W-1:0] mid_q;
	logic             srch_live_q;
	logic [IDX_W-1:0] fetch_idx_q;

	// per-item results
	logic [2:0]  status_q;
	logic [31:0] removed_q;
	logic [63:0] q_amount_q;
	logic [63:0] q_interest_q;

	// output registers
	logic [63:0] o_amount_q;
	logic [63:0] o_interest_q;
	logic [63:0] o_q_amount_q;
	logic [63:0] o_q_interest_q;
	logic [31:0] o_blocks_q;
	logic [31:0] o_removed_q;
	logic [2:0]  o_status_q;

	entry_t mem [ENTRIES];
	entry_t rdata_q;
	entry_t new_entry;

	// push arithmetic
	logic [63:0] base_a;
	logic [63:0] base_i;
	logic [63:0] sum_a;
	logic [64:0] sum_i;
	logic        a_ovf;
	logic        amt_nz;
	logic        tbl_full;
	logic [2:0]  push_status;
	logic        push_ok;
	logic        mem_we;

	// pop arithmetic
	logic [31:0]      bc_dec;
	logic             pop_drop;
	logic [CNT_W-1:0] count_m2;
	logic [CNT_W-1:0] lo_m1;
	logic             pop_from_live;
	logic [2:0]       exec_status;

	// search arithmetic
	logic             cmp_hit;
	logic [CNT_W-1:0] mid_ext;
	logic [CNT_W-1:0] step_lo;
	logic [CNT_W-1:0] step_hi;
	logic [CNT_W-1:0] lo_n;
	logic [CNT_W-1:0] hi_n;
	logic [CNT_W-1:0] mid_n;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;

	assign base_a   = (count_q != '0) ? last_amount_q : '0;
	assign base_i   = (count_q != '0) ? last_interest_q : '0;
	assign sum_a    = base_a + amt_q;
	assign sum_i    = {1'b0, base_i} + {1'b0, intr_q};
	assign a_ovf    = (base_a[63] == amt_q[63]) && (sum_a[63] != amt_q[63]);
	assign amt_nz   = (amt_q != '0);
	assign tbl_full = (count_q == CNT_W'(ENTRIES));

	always_comb begin
		priority if (a_ovf || sum_a[63]) begin
			push_status = ST_AMOUNT;
		end else if (sum_i[64]) begin
			push_status = ST_INTEREST;
		end else if (bc_q == 32'hFFFF_FFFF) begin
			push_status = ST_FULL;
		end else if (amt_nz && tbl_full) begin
			push_status = ST_FULL;
		end else begin
			push_status = ST_OK;
		end
	end

	assign push_ok   = (cmd_q == CMD_PUSH) && (push_status == ST_OK);
	assign mem_we    = ctl.exec && push_ok && amt_nz;
	assign new_entry = '{height: bc_q, amount: sum_a, interest: sum_i[63:0]};

	assign bc_dec        = bc_q - 32'd1;
	assign pop_drop      = (count_q != '0) && (last_height_q == bc_dec);
	assign count_m2      = count_q - CNT_W'(2);
	assign lo_m1         = lo_q - CNT_W'(1);
	assign pop_from_live = (h_q < bc_q);

	always_comb begin
		unique case (cmd_q)
			CMD_PUSH:    exec_status = push_status;
			CMD_POP_ONE: exec_status = (bc_q == '0) ? ST_EMPTY : ST_OK;
			default:     exec_status = ST_OK;
		endcase
	end

	assign stat.exec_search = ((cmd_q == CMD_POP_FROM) && pop_from_live) ||
	                          ((cmd_q == CMD_QUERY) && (bc_q != '0));
	assign stat.exec_fetch  = (cmd_q == CMD_POP_ONE) && (bc_q != '0) && pop_drop &&
	                          (count_q > CNT_W'(1));
	assign stat.srch_live   = srch_live_q;
	assign stat.srch_found  = (lo_q != '0);

	// one search step per cycle: compare the entry read last cycle, narrow, issue next read
	assign cmp_hit = (cmd_q == CMD_QUERY) ? (rdata_q.height <= h_q) : (rdata_q.height < h_q);
	assign mid_ext = CNT_W'(mid_q);
	assign step_lo = cmp_hit ? (mid_ext + CNT_W'(1)) : lo_q;
	assign step_hi = cmp_hit ? hi_q : mid_ext;
	assign lo_n    = ctl.exec ? '0 : step_lo;
	assign hi_n    = ctl.exec ? count_q : step_hi;
	assign mid_n   = lo_n + ((hi_n - lo_n) >> 1);

	assign rd_en   = ctl.exec || ctl.step || ctl.fetch;
	assign rd_addr = ctl.fetch ? fetch_idx_q : mid_n[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[IDX_W-1:0]] <= new_entry;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			bc_q        <= '0;
			srch_live_q <= 1'b0;
		end else begin
			if (ctl.exec || ctl.step) begin
				srch_live_q <= (lo_n < hi_n);
			end
			if (ctl.exec) begin
				unique case (cmd_q)
					CMD_PUSH: begin
						if (push_ok) begin
							bc_q <= bc_q + 32'd1;
							if (amt_nz) begin
								count_q <= count_q + CNT_W'(1);
							end
						end
					end
					CMD_POP_ONE: begin
						if (bc_q != '0) begin
							bc_q <= bc_dec;
							if (pop_drop) begin
								count_q <= count_q - CNT_W'(1);
							end
						end
					end
					CMD_POP_FROM: begin
						if (pop_from_live) begin
							bc_q <= h_q;
						end
					end
					default: begin
					end
				endcase
			end
			if (ctl.settle && (cmd_q == CMD_POP_FROM)) begin
				count_q <= lo_q;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q  <= cmd;
			amt_q  <= block_amount;
			intr_q <= block_interest;
			h_q    <= target_height;
		end
		if (ctl.exec || ctl.step) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_n[IDX_W-1:0];
		end
		if (ctl.exec) begin
			status_q     <= exec_status;
			removed_q    <= ((cmd_q == CMD_POP_FROM) && pop_from_live) ? (bc_q - h_q) : '0;
			q_amount_q   <= '0;
			q_interest_q <= '0;
			fetch_idx_q  <= count_m2[IDX_W-1:0];
			if (push_ok && amt_nz) begin
				last_height_q   <= bc_q;
				last_amount_q   <= sum_a;
				last_interest_q <= sum_i[63:0];
			end
		end
		if (ctl.settle) begin
			fetch_idx_q <= lo_m1[IDX_W-1:0];
		end
		if (ctl.load) begin
			if (cmd_q == CMD_QUERY) begin
				q_amount_q   <= rdata_q.amount;
				q_interest_q <= rdata_q.interest;
			end else begin
				last_height_q   <= rdata_q.height;
				last_amount_q   <= rdata_q.amount;
				last_interest_q <= rdata_q.interest;
			end
		end
		if (ctl.finish) begin
			o_amount_q     <= (count_q != '0) ? last_amount_q : '0;
			o_interest_q   <= (count_q != '0) ? last_interest_q : '0;
			o_q_amount_q   <= q_amount_q;
			o_q_interest_q <= q_interest_q;
			o_blocks_q     <= bc_q;
			o_removed_q    <= removed_q;
			o_status_q     <= status_q;
		end
	end

	assign total_amount       = $signed(o_amount_q);
	assign total_interest     = o_interest_q;
	assign amount_at_height   = $signed(o_q_amount_q);
	assign interest_at_height = o_q_interest_q;
	assign blocks_now         = o_blocks_q;
	assign blocks_removed     = o_removed_q;
	assign status             = o_status_q;

endmodule

>>> rtl/core/deposit_prefix_sum_index.sv
// Top level of the deposit prefix-sum index: sequencer plus datapath.
//
//   channel | handshake                | payload
//   --------+--------------------------+-----------------------------------------------
//   in      | in_valid / in_stall      | cmd, block_amount, block_interest, target_height
//   out     | out_valid / out_stall    | total_amount, total_interest, amount_at_height,
//           |                          | interest_at_height, blocks_now, blocks_removed,
//           |                          | status
//
// One beat is worked at a time. Push and pop-one without refresh go from accept through
// an execute step to the result; a pop-one that drops the last entry adds a fetch and a
// load step to reread the new last entry. Pop-from and query run a binary search on the
// single-read entry memory at one probe per cycle.
// The next beat is accepted the cycle after a result is registered.
// Reset (arst_n low) empties the table and chain at once; no memory clearing pass.
// in_stall is high while a beat is in work; a finished result waits in the output
// register under out_stall, and the next beat may be accepted meanwhile.
module deposit_prefix_sum_index (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic signed [63:0] block_amount,
	input  logic [63:0]        block_interest,
	input  logic [31:0]        target_height,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [63:0] total_amount,
	output logic [63:0]        total_interest,
	output logic signed [63:0] amount_at_height,
	output logic [63:0]        interest_at_height,
	output logic [31:0]        blocks_now,
	output logic [31:0]        blocks_removed,
	output logic [2:0]         status
);
	import dpsi_pkg::*;

	dp_ctl_t  ctl;
	dp_stat_t stat;

	// sequencer: handshakes and step order
	dpsi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	// datapath: entry memory, totals, search, result registers
	dpsi_datapath u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.ctl                (ctl),
		.stat               (stat),
		.cmd                (cmd),
		.block_amount       (block_amount),
		.block_interest     (block_interest),
		.target_height      (target_height),
		.total_amount       (total_amount),
		.total_interest     (total_interest),
		.amount_at_height   (amount_at_height),
		.interest_at_height (interest_at_height),
		.blocks_now         (blocks_now),
		.blocks_removed     (blocks_removed),
		.status             (status)
	);

endmodule
